### sv/fbbe_pkg.sv
// Shared types and constants of the filament bond and bend energy block.
// No dependencies; the top level, the checker and the testbench import this package.
package fbbe_pkg;

  localparam int DIMENSIONS_DEF  = 3;
  localparam int COORD_WIDTH_DEF = 32;

  // Field and datapath widths
  localparam int POS_W      = 32;                  // Q16.16 coordinate
  localparam int MAG_W      = 32;                  // |coordinate difference|
  localparam int SQ_W       = 2 * MAG_W;           // squared difference
  localparam int SUM_W      = SQ_W + 2;            // sum of up to three squares
  localparam int LEN_W      = SUM_W / 2;           // bond length
  localparam int STIFF_W    = 32;                  // configuration registers
  localparam int UNIT_FRAC  = 30;                  // Q2.30 unit vector
  localparam int UNIT_W     = 32;
  localparam int UMAG_W     = UNIT_FRAC + 1;       // unit magnitude, at most 1.0
  localparam int DIV_N_W    = MAG_W + UNIT_FRAC;   // dividend of the normalization
  localparam int STSQ_W     = 2 * LEN_W;           // (len - rest)^2
  localparam int STK_W      = STSQ_W + STIFF_W;    // k * (len - rest)^2
  localparam int ENERGY_W   = 64;
  localparam int STR_SHIFT  = 17;
  localparam int TERM_W     = ENERGY_W - 1;
  localparam int STR_OVER_LSB = STR_SHIFT + TERM_W;
  localparam int DOT_W      = 2 * UMAG_W;          // one Q2.60 product
  localparam int BEND_W     = 62;                  // 1.0 - dot, at most 2.0 in Q2.60
  localparam int BEND_P_W   = BEND_W + STIFF_W;
  localparam int BEND_SHIFT = 44;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEND    = 2'd2;

  localparam logic [STIFF_W-1:0]  STIFF_RESET = 32'h0001_0000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX  = {1'b0, {(ENERGY_W-1){1'b1}}};

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    chain_start;
    logic                    frame_end;
  } in_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy_total;
    logic                       zero_bond_seen;
    logic                       saturated;
  } out_t;

endpackage

### sv/filament_bond_bend_energy.sv
// Top level: bond stretch and bend energy of streamed polymer chains.
// Depends on fbbe_pkg, fbbe_smul, fbbe_sqrt and fbbe_div.
//
//  port group  | direction | handshake            | payload
//  ------------+-----------+----------------------+---------------------------
//  in          | into      | in_valid / in_ready  | in_data (fbbe_pkg::in_t)
//  out         | out of    | out_valid / out_ready| out_data (fbbe_pkg::out_t)
//  cfg         | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A monomer that forms no bond starts no arithmetic pass. A monomer that forms
// a bond passes in turn through the serial squares, the square root, the divide
// and stretch square, the stretch and dot products and the bend product.
// Frame end passes through S_EMIT to load the output register, and waits there
// only while the previous total is still unread.
// Reset is synchronous; cfg_ready is always high.
module filament_bond_bend_energy #(
  parameter int DIMENSIONS  = fbbe_pkg::DIMENSIONS_DEF,
  parameter int COORD_WIDTH = fbbe_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fbbe_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fbbe_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbbe_pkg::STIFF_W-1:0]     cfg_data
);

  import fbbe_pkg::*;

  localparam int CE = (COORD_WIDTH > POS_W) ? POS_W : COORD_WIDTH;
  localparam int SH = POS_W - CE;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_ROOT = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_BEND = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state;

  logic [STIFF_W-1:0] stretch_k, rest_len, bend_k;

  logic signed [POS_W-1:0]  prev_pos  [DIMENSIONS];
  logic signed [UNIT_W-1:0] prev_unit [DIMENSIONS];
  logic [MAG_W-1:0]         bond_mag  [DIMENSIONS];
  logic                     bond_neg  [DIMENSIONS];
  logic [UMAG_W-1:0]        unit_mag  [DIMENSIONS];
  logic                     unit_neg  [DIMENSIONS];

  logic has_pos, has_bond, frame_last, zero_flag, sat_flag;
  logic [ENERGY_W-1:0] energy_sum;
  logic [TERM_W-1:0]   stretch_term;
  logic                stretch_over, stretch_pend;

  // Per-axis datapath
  logic signed [POS_W-1:0] p_sel [3];
  logic signed [POS_W-1:0] p_in  [DIMENSIONS];
  logic signed [POS_W:0]   d_in  [DIMENSIONS];
  logic [SQ_W-1:0]         sq_prod [DIMENSIONS];
  logic                    sq_done [DIMENSIONS];
  logic [UMAG_W-1:0]       div_q   [DIMENSIONS];
  logic [UMAG_W-1:0]       cur_mag [DIMENSIONS];
  logic [UMAG_W-1:0]       prev_mag [DIMENSIONS];
  logic [DOT_W-1:0]        dot_prod [DIMENSIONS];

  logic              accept, bond_go;
  logic              sq_start, root_start, root_done, stsq_start, stsq_done;
  logic              stk_start, stk_done, bend_start, bend_done;
  logic [SUM_W-1:0]  root_rad;
  logic [LEN_W-1:0]  root_val;
  logic signed [LEN_W:0] len_diff;
  logic [LEN_W-1:0]  len_dev;
  logic [STSQ_W-1:0] stsq_prod;
  logic [STK_W-1:0]  stk_prod;
  logic signed [ENERGY_W-1:0] dot_sum, bend_wide;
  logic [BEND_W-1:0]   bend_val;
  logic [BEND_P_W-1:0] bend_prod;

  logic                acc_en, acc_over, acc_sat;
  logic [TERM_W-1:0]   acc_term;
  logic [ENERGY_W-1:0] acc_wide;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign bond_go   = accept && has_pos && !in_data.chain_start;

  // Sign-extend each coordinate from its low CE bits
  assign p_sel[0] = in_data.pos_x;
  assign p_sel[1] = in_data.pos_y;
  assign p_sel[2] = in_data.pos_z;

  assign sq_start   = bond_go;
  assign root_start = (state == S_SQ) && sq_done[0];
  assign stsq_start = (state == S_ROOT) && root_done;
  assign stk_start  = (state == S_DIV) && stsq_done;
  assign bend_start = (state == S_MUL) && stk_done;

  for (genvar k = 0; k < DIMENSIONS; k++) begin : g_axis
    assign p_in[k]     = (p_sel[k] <<< SH) >>> SH;
    assign d_in[k]     = {p_in[k][POS_W-1], p_in[k]} - {prev_pos[k][POS_W-1], prev_pos[k]};
    assign cur_mag[k]  = (root_val == '0) ? '0 : div_q[k];
    assign prev_mag[k] = prev_unit[k][UNIT_W-1] ? UMAG_W'(-prev_unit[k])
                                                : UMAG_W'(prev_unit[k]);

    fbbe_smul #(.AW(MAG_W), .BW(MAG_W)) u_sq (
      .clk(clk), .rst(rst), .start(sq_start),
      .a(d_in[k][POS_W] ? MAG_W'(-d_in[k]) : MAG_W'(d_in[k])),
      .b(d_in[k][POS_W] ? MAG_W'(-d_in[k]) : MAG_W'(d_in[k])),
      .done(sq_done[k]), .prod(sq_prod[k])
    );

    fbbe_div #(.NW(DIV_N_W), .DW(LEN_W), .QW(UMAG_W)) u_div (
      .clk(clk), .rst(rst), .start(stsq_start),
      .dividend({bond_mag[k], {UNIT_FRAC{1'b0}}}), .divisor(root_val),
      .done(), .quot(div_q[k])
    );

    fbbe_smul #(.AW(UMAG_W), .BW(UMAG_W)) u_dot (
      .clk(clk), .rst(rst), .start(stk_start),
      .a(prev_mag[k]), .b(cur_mag[k]),
      .done(), .prod(dot_prod[k])
    );
  end

  // Sum of squares and the signed dot product across the axes
  always_comb begin
    root_rad = '0;
    dot_sum  = '0;
    for (int k = 0; k < DIMENSIONS; k++) begin
      root_rad = root_rad + SUM_W'(sq_prod[k]);
      if (prev_unit[k][UNIT_W-1] ^ unit_neg[k]) begin
        dot_sum = dot_sum - $signed(ENERGY_W'(dot_prod[k]));
      end else begin
        dot_sum = dot_sum + $signed(ENERGY_W'(dot_prod[k]));
      end
    end
  end

  assign bend_wide = $signed(ENERGY_W'(1) << (2 * UNIT_FRAC)) - dot_sum;
  assign bend_val  = bend_wide[BEND_W-1:0];

  assign len_diff = $signed({1'b0, root_val}) - $signed((LEN_W+1)'(rest_len));
  assign len_dev  = len_diff[LEN_W] ? LEN_W'(-len_diff) : LEN_W'(len_diff);

  fbbe_sqrt #(.RW(LEN_W)) u_root (
    .clk(clk), .rst(rst), .start(root_start), .radicand(root_rad),
    .done(root_done), .root(root_val)
  );

  fbbe_smul #(.AW(LEN_W), .BW(LEN_W)) u_stsq (
    .clk(clk), .rst(rst), .start(stsq_start), .a(len_dev), .b(len_dev),
    .done(stsq_done), .prod(stsq_prod)
  );

  fbbe_smul #(.AW(STSQ_W), .BW(STIFF_W)) u_stk (
    .clk(clk), .rst(rst), .start(stk_start), .a(stsq_prod), .b(stretch_k),
    .done(stk_done), .prod(stk_prod)
  );

  fbbe_smul #(.AW(BEND_W), .BW(STIFF_W)) u_bend (
    .clk(clk), .rst(rst), .start(bend_start), .a(bend_val), .b(bend_k),
    .done(bend_done), .prod(bend_prod)
  );

  // Pick the term to add this cycle: stretch first, bend when it lands and the chain had an earlier bond
  always_comb begin
    acc_en   = 1'b0;
    acc_over = 1'b0;
    acc_term = '0;
    priority if ((state == S_BEND) && stretch_pend) begin
      acc_en   = 1'b1;
      acc_over = stretch_over;
      acc_term = stretch_term;
    end else if ((state == S_BEND) && bend_done && has_bond) begin
      acc_en   = 1'b1;
      acc_term = TERM_W'(bend_prod[BEND_P_W-1:BEND_SHIFT]);
    end else begin
      acc_en   = 1'b0;
    end
    acc_wide = {1'b0, energy_sum[ENERGY_W-2:0]} + {1'b0, acc_term};
    acc_sat  = acc_over || acc_wide[ENERGY_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stretch_k    <= STIFF_RESET;
      rest_len     <= STIFF_RESET;
      bend_k       <= STIFF_RESET;
      has_pos      <= 1'b0;
      has_bond     <= 1'b0;
      zero_flag    <= 1'b0;
      sat_flag     <= 1'b0;
      energy_sum   <= '0;
      out_valid    <= 1'b0;
      stretch_pend <= 1'b0;
      for (int k = 0; k < DIMENSIONS; k++) begin
        prev_unit[k] <= '0;
        prev_pos[k]  <= '0;
      end
    end else begin
      // Take register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STRETCH: stretch_k <= cfg_data;
          REG_REST:    rest_len  <= cfg_data;
          REG_BEND:    bend_k    <= cfg_data;
          default:     ;
        endcase
      end

      // Drop the output transaction once taken
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      // Accumulate with saturation
      if (acc_en) begin
        energy_sum   <= acc_sat ? ENERGY_MAX : acc_wide;
        stretch_pend <= 1'b0;
        if (acc_sat) begin
          sat_flag <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int k = 0; k < DIMENSIONS; k++) begin
              prev_pos[k] <= p_in[k];
              bond_neg[k] <= d_in[k][POS_W];
              bond_mag[k] <= d_in[k][POS_W] ? MAG_W'(-d_in[k]) : MAG_W'(d_in[k]);
            end
            has_pos    <= 1'b1;
            frame_last <= in_data.frame_end;
            if (in_data.chain_start) begin
              has_bond <= 1'b0;
            end
            priority if (has_pos && !in_data.chain_start) begin
              state <= S_SQ;
            end else if (in_data.frame_end) begin
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SQ: begin
          if (sq_done[0]) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            if (root_val == '0) begin
              zero_flag <= 1'b1;
            end
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // Dividers finish before the stretch square
          if (stsq_done) begin
            for (int k = 0; k < DIMENSIONS; k++) begin
              unit_mag[k] <= cur_mag[k];
              unit_neg[k] <= bond_neg[k];
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (stk_done) begin
            stretch_term <= stk_prod[STR_OVER_LSB-1:STR_SHIFT];
            stretch_over <= |stk_prod[STK_W-1:STR_OVER_LSB];
            stretch_pend <= 1'b1;
            state        <= S_BEND;
          end
        end
        S_BEND: begin
          if (bend_done) begin
            for (int k = 0; k < DIMENSIONS; k++) begin
              prev_unit[k] <= unit_neg[k] ? -$signed(UNIT_W'(unit_mag[k]))
                                          : $signed(UNIT_W'(unit_mag[k]));
            end
            has_bond <= 1'b1;
            state    <= frame_last ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.energy_total   <= $signed(energy_sum);
            out_data.zero_bond_seen <= zero_flag;
            out_data.saturated      <= sat_flag;
            energy_sum              <= '0;
            zero_flag               <= 1'b0;
            sat_flag                <= 1'b0;
            has_pos                 <= 1'b0;
            has_bond                <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A saturated total reads as the largest value
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |-> out_data.energy_total == $signed(ENERGY_MAX))
    else $error("saturated total is not the maximum");

  // The running sum never goes negative
  a_sum_pos: assert property (@(posedge clk) disable iff (rst)
    !energy_sum[ENERGY_W-1])
    else $error("energy sum went negative");

  // A monomer that continues a chain starts the bond pipeline
  a_bond_go: assert property (@(posedge clk) disable iff (rst)
    bond_go |=> state == S_SQ)
    else $error("bond not started");

  // The stretch term is added before the bend term lands
  a_stretch_first: assert property (@(posedge clk) disable iff (rst)
    bend_done |-> !stretch_pend)
    else $error("stretch term still pending at bend result");

endmodule

### sv/fbbe_smul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the top level for every product.
module fbbe_smul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   step_sum;

  // Add the multiplicand when the low bit is set, then shift right
  assign step_sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : '0);
  assign prod     = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= CW'(BW);
        busy <= 1'b1;
      end else if (busy) begin
        hi  <= step_sum[AW:1];
        lo  <= {step_sum[0], lo[BW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/fbbe_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on nothing; the top level uses it for the bond length.
module fbbe_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW:0]     rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RW+2:0]   t;
  logic [RW+2:0]   trial;
  logic            fits;

  // Bring down two radicand bits and try the next root bit
  assign t     = {rem, rad[2*RW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
        busy <= 1'b1;
      end else if (busy) begin
        rad  <= {rad[2*RW-3:0], 2'b00};
        rem  <= fits ? (RW+1)'(t - trial) : t[RW:0];
        root <= {root[RW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/fbbe_div.sv
// Restoring divider, one quotient bit per cycle; the quotient must fit QW bits.
// Depends on nothing; the top level uses one per axis for the unit bond.
module fbbe_div #(
  parameter int NW = 62,
  parameter int DW = 33,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] d_r;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   t;
  logic          fits;

  // Shift in the next dividend bit; the low register turns into the quotient
  assign t    = {rem, quot[QW-1]};
  assign fits = (t >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d_r  <= divisor;
        rem  <= DW'(dividend[NW-1:QW]);
        quot <= dividend[QW-1:0];
        cnt  <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? DW'(t - {1'b0, d_r}) : t[DW-1:0];
        quot <= {quot[QW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### tb/fbbe_checker.sv
// Checker for filament_bond_bend_energy: watches the input, output and
// configuration channels, predicts each frame total and compares. Uses fbbe_pkg.
module fbbe_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  fbbe_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  fbbe_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fbbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbbe_pkg::STIFF_W-1:0]   cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             totals_seen,
  output int                             bonds_seen
);
  import fbbe_pkg::*;

  // Shadow registers and chain state
  logic [31:0]    k_stretch, len_rest, k_bend;
  longint         last_pos[3];
  longint         last_unit[3];
  logic [63:0]    energy_acc;
  bit             have_pos, have_bond, zero_flag, sat_flag;
  out_t           frame_totals[$];

  function automatic logic [63:0] floor_sqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] cw;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cw = c;
      if (cw * cw <= n) r = c;
    end
    return r;
  endfunction

  task automatic accumulate(logic [63:0] term, bit over);
    logic [63:0] room;
    room = ENERGY_MAX - energy_acc;
    if (over || term > room) begin
      energy_acc = ENERGY_MAX;
      sat_flag   = 1'b1;
    end else begin
      energy_acc = energy_acc + term;
    end
  endtask

  task automatic drop_history();
    have_pos  = 1'b0;
    have_bond = 1'b0;
    for (int k = 0; k < 3; k++) begin
      last_pos[k]  = 0;
      last_unit[k] = 0;
    end
  endtask

  // Add stretch and bend energy of the bond ending at p
  task automatic add_bond(longint p[3]);
    longint       d[3];
    logic [63:0]  m[3];
    longint       unit[3];
    logic [127:0] mw, sqsum, sq, mdw, t, bendw;
    logic [191:0] prod, kw, sqw;
    logic [63:0]  len, md, u, bend;
    longint       diff, dot;
    sqsum = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = p[k] - last_pos[k];
      m[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
      mw = m[k];
      sqsum = sqsum + mw * mw;
      unit[k] = 0;
    end
    len = floor_sqrt(sqsum);
    bonds_seen++;

    diff = longint'(len) - longint'({32'd0, len_rest});
    md   = (diff < 0) ? 64'(-diff) : 64'(diff);
    mdw  = md;
    sq   = mdw * mdw;
    kw   = k_stretch;
    sqw  = sq;
    prod = kw * sqw;
    if (prod[191:80] != 0) accumulate('0, 1'b1);
    else accumulate({1'b0, prod[79:17]}, 1'b0);

    if (len == 0) begin
      zero_flag = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        u = (m[k] << 30) / len;
        unit[k] = (d[k] < 0) ? -longint'(u) : longint'(u);
      end
    end

    if (have_bond) begin
      dot = 0;
      for (int k = 0; k < 3; k++) dot += last_unit[k] * unit[k];
      bend  = 64'((longint'(1) <<< 60) - dot);
      bendw = bend;
      t     = {96'd0, k_bend} * bendw;
      accumulate(t[107:44], 1'b0);
    end
    for (int k = 0; k < 3; k++) last_unit[k] = unit[k];
    have_bond = 1'b1;
  endtask

  task automatic predict_monomer(in_t it);
    longint p[3];
    out_t   res;
    p[0] = longint'(it.pos_x);
    p[1] = longint'(it.pos_y);
    p[2] = longint'(it.pos_z);
    if (it.chain_start) drop_history();
    if (have_pos) add_bond(p);
    for (int k = 0; k < 3; k++) last_pos[k] = p[k];
    have_pos = 1'b1;
    if (it.frame_end) begin
      res.energy_total   = energy_acc;
      res.zero_bond_seen = zero_flag;
      res.saturated      = sat_flag;
      frame_totals.push_back(res);
      energy_acc = '0;
      zero_flag  = 1'b0;
      sat_flag   = 1'b0;
      drop_history();
    end
  endtask

  // Track each transaction on the three channels
  always @(posedge clk) begin
    if (rst) begin
      k_stretch  = STIFF_RESET;
      len_rest   = STIFF_RESET;
      k_bend     = STIFF_RESET;
      energy_acc = '0;
      zero_flag  = 1'b0;
      sat_flag   = 1'b0;
      drop_history();
      frame_totals.delete();
      errors      = 0;
      totals_seen = 0;
      bonds_seen  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STRETCH: k_stretch = cfg_data;
          REG_REST:    len_rest  = cfg_data;
          REG_BEND:    k_bend    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_monomer(in_data);
      if (out_valid && out_ready) begin
        totals_seen++;
        if (frame_totals.size() == 0) begin
          $error("unexpected total %h", out_data.energy_total);
          errors++;
        end else begin
          out_t want;
          want = frame_totals.pop_front();
          if (want.energy_total !== out_data.energy_total) begin
            $error("energy_total: expected %h, got %h",
                   want.energy_total, out_data.energy_total);
            errors++;
          end
          if (want.zero_bond_seen !== out_data.zero_bond_seen) begin
            $error("zero_bond_seen: expected %b, got %b",
                   want.zero_bond_seen, out_data.zero_bond_seen);
            errors++;
          end
          if (want.saturated !== out_data.saturated) begin
            $error("saturated: expected %b, got %b",
                   want.saturated, out_data.saturated);
            errors++;
          end
        end
      end
    end
    pending = frame_totals.size();
  end

endmodule

### tb/filament_bond_bend_energy_tb.sv
// Testbench top for filament_bond_bend_energy: drives polymer frames and
// register settings, gives the verdict. Uses fbbe_pkg and fbbe_checker.
module filament_bond_bend_energy_tb;
  import fbbe_pkg::*;

  // Index past the register list; writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk, rst;
  logic                 in_valid, in_ready, out_valid, out_ready;
  logic                 cfg_valid, cfg_ready;
  in_t                  in_data;
  out_t                 out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STIFF_W-1:0]   cfg_data;
  int                   errors, pending, totals_seen, bonds_seen;
  int                   items_sent;
  bit                   send_calm;
  int                   walk[3];

  filament_bond_bend_energy dut (.*);

  fbbe_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("filament_bond_bend_energy_tb: FAIL");
    $finish;
  end

  // Receiver: random stalls, one calm stretch and one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 30000 && cyc < 34000) out_ready <= 1'b0;
      else if (cyc >= 50000 && cyc < 70000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 29);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Present one monomer; valid stays high into the next transaction
  task automatic send(int x, int y, int z, bit cs, bit fe);
    in_t it;
    if (!send_calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.chain_start = cs;
    it.frame_end = fe;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Step each axis by up to reach from the current walk position
  task automatic step_walk(int reach);
    for (int k = 0; k < 3; k++) walk[k] += $urandom_range(0, 2 * reach) - reach;
  endtask

  // One frame of 1..3 chains; kind picks walk, wild, stuck or no-start
  task automatic send_frame();
    int chains, mons, kind, reach;
    chains = $urandom_range(1, 3);
    for (int c = 0; c < chains; c++) begin
      mons  = $urandom_range(1, 5);
      kind  = $urandom_range(99);
      reach = ($urandom_range(3) == 0) ? $urandom_range(1, 1 << 24) : 65536;
      for (int k = 0; k < 3; k++) walk[k] = $urandom_range(0, 1 << 22) - (1 << 21);
      for (int i = 0; i < mons; i++) begin
        if (kind < 12) begin
          for (int k = 0; k < 3; k++) walk[k] = $urandom();
        end else if (kind < 20 && i > 0) begin
          if ($urandom_range(1)) step_walk(reach);
        end else if (i > 0) begin
          step_walk(reach);
        end
        send(walk[0], walk[1], walk[2],
             (i == 0) && !(kind >= 20 && kind < 26 && c > 0),
             (c == chains - 1) && (i == mons - 1));
      end
    end
  endtask

  // Let the block drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  initial begin
    logic [31:0] kset[3];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STRETCH;
    cfg_data = '0;
    items_sent = 0;
    send_calm = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, zero bond, bend, extremes, lone monomers
    send(0, 0, 0, 1, 0);
    send(65536, 0, 0, 0, 0);
    send(65536, 65536, 0, 0, 0);
    send(65536, 65536, 0, 0, 0);
    send(0, 65536, 65536, 0, 1);
    send(5, 5, 5, 1, 1);
    send(7, 8, 9, 0, 0);
    send(-7, 3, 1, 0, 1);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0);
    send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
    send(-65536, 0, 0, 1, 0);
    send(0, 0, 0, 0, 0);
    send(65536, 0, 0, 0, 0);
    send(131072, 0, 0, 1, 0);
    send(131072, 65536, 0, 0, 1);
    settle();

    // Phases of register settings, extremes first, unused index too
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: kset = '{32'd0, 32'd0, 32'd0};
        1: kset = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        2: kset = '{STIFF_RESET, STIFF_RESET, STIFF_RESET};
        default: kset = '{$urandom(), $urandom_range(0, 1 << 20), $urandom()};
      endcase
      write_reg(REG_STRETCH, kset[0]);
      write_reg(REG_REST, kset[1]);
      write_reg(REG_BEND, kset[2]);
      write_reg(REG_SPARE, $urandom());
      send_calm = (ph == 3);
      if (ph == 1) begin
        send(0, 0, 0, 1, 0);
        send(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1);
      end
      while (items_sent < 40 + (ph + 1) * 120) send_frame();
      send_calm = 1'b0;
      settle();
    end

    $display("covered %0d monomers, %0d bonds, %0d frame totals over six settings",
             items_sent, bonds_seen, totals_seen);
    if (errors == 0 && pending == 0) $display("filament_bond_bend_energy_tb: PASS");
    else $display("filament_bond_bend_energy_tb: FAIL");
    $finish;
  end

endmodule
